>>> rtl/lzwd_pkg.sv
package lzwd_pkg;

    // Default history window, in bytes.
    localparam int unsigned HISTORY_DEPTH_DEF = 4096;

    // Depth of the command queue between parser and copy engine.
    localparam int unsigned CMD_QUEUE_DEPTH = 4;

    // Header tag: 'L' in the first byte, 'Z' in the second.
    localparam logic [7:0]  TAG_CHAR_L   = 8'h4C;
    localparam logic [7:0]  TAG_CHAR_Z   = 8'h5A;
    localparam logic [15:0] HEADER_TAG   = {TAG_CHAR_Z, TAG_CHAR_L};

    // Token layout: length minus MIN_MATCH in the top nibble, distance minus one in the low 12 bits.
    localparam int unsigned DIST_BITS    = 12;
    localparam logic [4:0]  MIN_MATCH    = 5'd3;
    localparam logic [DIST_BITS-1:0] DIST_MASK = 12'hFFF;

    // Parser phases.
    typedef enum logic [5:0] {
        PH_IDLE   = 6'b000001,
        PH_HEADER = 6'b000010,
        PH_FLAG   = 6'b000100,
        PH_BITS   = 6'b001000,
        PH_TOKEN2 = 6'b010000,
        PH_DONE   = 6'b100000
    } phase_t;

    // One command for the copy engine: a literal or a back-reference copy.
    typedef struct packed {
        logic        is_lit;
        logic [7:0]  data;
        logic [4:0]  count;
        logic        dist_one;
        logic        done_end;
        logic [23:0] size;
    } cmd_info_t;

    localparam int unsigned CMD_INFO_W = $bits(cmd_info_t);

endpackage

>>> rtl/lzss_window_decompressor.sv
// LZSS decoder with a history window of HISTORY_DEPTH bytes (4096 by default).
// Compressed bytes enter one per beat on the s_axis side: tuser marks the first
// byte of a buffer, tlast its final byte. The block reads a header (an optional
// 'L','Z' tag, then a 24-bit little-endian decoded size), then flag bytes read
// LSB first, each bit selecting a literal byte or a two-byte token that copies
// 3 to 18 bytes from 1 to 4096 bytes back. Decoded bytes leave one per beat on
// the m_axis side; tlast marks the last byte caused by one input beat and tuser
// the byte that reaches the decoded size. A copy that would reach before the
// first output byte gives no bytes, and output stops at the decoded size. Input
// bytes seen before a start mark, or after the last byte or the decoded size,
// are dropped. A parser takes one input beat per cycle while the queue has
// room and places literal and copy commands in a four-entry queue; a copy
// engine works them off, one output byte per cycle while the output side is
// not stalled, through a history RAM with one write and one registered read
// port. The engine pops a new command only once its current one is issued,
// and the parser runs ahead of the engine by up to four commands.
module lzss_window_decompressor #(
    parameter int unsigned HISTORY_DEPTH = lzwd_pkg::HISTORY_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tuser,   // [0] stream_start
    input  logic        s_axis_tlast,   // stream_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] out_byte, [31:8] expected_size
    output logic        m_axis_tuser,   // [0] stream_done
    output logic        m_axis_tlast    // run_last
);

    import lzwd_pkg::*;

    localparam int unsigned AW = $clog2(HISTORY_DEPTH);
    localparam int unsigned QW = CMD_INFO_W + 2 * AW;

    logic          cmd_valid;
    logic          cmd_ready;
    cmd_info_t     cmd_info;
    logic [AW-1:0] cmd_rd_idx;
    logic [AW-1:0] cmd_wr_idx;

    logic          q_full;
    logic          q_not_empty;
    logic          q_pop;
    logic [QW-1:0] q_data;

    cmd_info_t     q_info;
    logic [AW-1:0] q_rd_idx;
    logic [AW-1:0] q_wr_idx;

    logic [7:0]    out_byte;
    logic [23:0]   out_size;

    assign cmd_ready = !q_full;

    // The parser: header, flag bits, token decode and the output count.
    lzwd_front #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .AW            (AW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .in_start   (s_axis_tuser),
        .in_last    (s_axis_tlast),
        .cmd_ready  (cmd_ready),
        .cmd_valid  (cmd_valid),
        .cmd_info   (cmd_info),
        .cmd_rd_idx (cmd_rd_idx),
        .cmd_wr_idx (cmd_wr_idx)
    );

    lzwd_cmd_fifo #(
        .WIDTH (QW),
        .DEPTH (CMD_QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_valid),
        .push_data ({cmd_rd_idx, cmd_wr_idx, cmd_info}),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_data)
    );

    assign q_info   = q_data[CMD_INFO_W-1:0];
    assign q_wr_idx = q_data[CMD_INFO_W +: AW];
    assign q_rd_idx = q_data[CMD_INFO_W + AW +: AW];

    // The copy engine: history RAM and the output register.
    lzwd_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .AW            (AW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (q_not_empty),
        .cmd_pop    (q_pop),
        .cmd_info   (q_info),
        .cmd_rd_idx (q_rd_idx),
        .cmd_wr_idx (q_wr_idx),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_byte   (out_byte),
        .out_last   (m_axis_tlast),
        .out_done   (m_axis_tuser),
        .out_size   (out_size)
    );

    assign m_axis_tdata = {out_size, out_byte};

endmodule

>>> rtl/lzwd_ram.sv
module lzwd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/lzwd_front.sv
module lzwd_front #(
    parameter int unsigned HISTORY_DEPTH = lzwd_pkg::HISTORY_DEPTH_DEF,
    parameter int unsigned AW = $clog2(HISTORY_DEPTH)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            in_byte,
    input  logic                  in_start,
    input  logic                  in_last,
    input  logic                  cmd_ready,
    output logic                  cmd_valid,
    output lzwd_pkg::cmd_info_t   cmd_info,
    output logic [AW-1:0]         cmd_rd_idx,
    output logic [AW-1:0]         cmd_wr_idx
);

    import lzwd_pkg::*;

    localparam logic [AW:0] DEPTH_EXT = (AW+1)'(HISTORY_DEPTH);

    phase_t        phase_reg, phase_next;
    logic [2:0]    hc_reg, hc_next;
    logic [15:0]   held_reg, held_next;
    logic [23:0]   target_reg, target_next;
    logic [23:0]   prod_reg, prod_next;
    logic [7:0]    flag_reg, flag_next;
    logic [3:0]    bit_reg, bit_next;
    logic [7:0]    th_reg, th_next;
    logic [AW-1:0] wr_reg, wr_next;

    logic          accept;
    logic          emit;

    assign in_ready = cmd_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        phase_t        eff_phase;
        logic [2:0]    eff_hc;
        logic [15:0]   eff_held;
        logic [23:0]   eff_target;
        logic [23:0]   eff_prod;
        logic [AW-1:0] eff_wr;
        logic          finish;
        logic          advance;
        logic [23:0]   prod_new;
        logic [4:0]    n;
        logic [4:0]    len;
        logic [12:0]   back_dist;
        logic [23:0]   rem;
        logic [AW:0]   wr_sum;
        logic [AW:0]   dist_ext;
        logic [AW:0]   src;
        logic [3:0]    bit_new;

        eff_phase  = in_start ? PH_HEADER : phase_reg;
        eff_hc     = in_start ? 3'd0 : hc_reg;
        eff_held   = in_start ? 16'd0 : held_reg;
        eff_target = in_start ? 24'd0 : target_reg;
        eff_prod   = in_start ? 24'd0 : prod_reg;
        eff_wr     = in_start ? '0 : wr_reg;

        phase_next  = eff_phase;
        hc_next     = eff_hc;
        held_next   = eff_held;
        target_next = eff_target;
        prod_next   = eff_prod;
        wr_next     = eff_wr;
        flag_next   = flag_reg;
        bit_next    = bit_reg;
        th_next     = th_reg;

        finish   = 1'b0;
        advance  = 1'b0;
        emit     = 1'b0;
        n        = 5'd0;
        prod_new = eff_prod;
        bit_new  = bit_reg + 4'd1;

        len       = {1'b0, th_reg[7:4]} + MIN_MATCH;
        back_dist = {1'b0, th_reg[3:0] & DIST_MASK[11:8], in_byte} + 13'd1;
        rem       = eff_target - eff_prod;
        dist_ext  = (AW+1)'(back_dist);
        if ({1'b0, eff_wr} >= dist_ext)
        begin
            src = {1'b0, eff_wr} - dist_ext;
        end
        else
        begin
            src = {1'b0, eff_wr} + DEPTH_EXT - dist_ext;
        end

        cmd_info          = '0;
        cmd_info.data     = in_byte;
        cmd_info.dist_one = (back_dist == 13'd1);
        cmd_rd_idx        = src[AW-1:0];
        cmd_wr_idx        = eff_wr;

        unique case (eff_phase)
            PH_HEADER:
            begin
                hc_next = eff_hc + 3'd1;
                if (eff_hc == 3'd0)
                begin
                    held_next = {8'd0, in_byte};
                end
                else if (eff_hc == 3'd1)
                begin
                    held_next = {in_byte, eff_held[7:0]};
                end
                else if (eff_hc == 3'd2)
                begin
                    if (eff_held == HEADER_TAG)
                    begin
                        target_next = {16'd0, in_byte};
                    end
                    else
                    begin
                        target_next = {in_byte, eff_held};
                        finish      = 1'b1;
                    end
                end
                else if (eff_hc == 3'd3)
                begin
                    target_next = {eff_target[23:16], in_byte, eff_target[7:0]};
                end
                else
                begin
                    target_next = {in_byte, eff_target[15:0]};
                    finish      = 1'b1;
                end
            end
            PH_FLAG:
            begin
                flag_next  = in_byte;
                bit_next   = 4'd0;
                phase_next = PH_BITS;
            end
            PH_BITS:
            begin
                if (flag_reg[bit_reg[2:0]])
                begin
                    n       = 5'd1;
                    emit    = 1'b1;
                    advance = 1'b1;
                    cmd_info.is_lit = 1'b1;
                end
                else
                begin
                    th_next    = in_byte;
                    phase_next = PH_TOKEN2;
                end
            end
            PH_TOKEN2:
            begin
                // A copy reaching before the first output byte gives nothing;
                // one running past the decoded size is cut at that size.
                if (eff_prod < 24'(back_dist) || eff_prod >= eff_target)
                begin
                    n = 5'd0;
                end
                else if (rem < 24'(len))
                begin
                    n = rem[4:0];
                end
                else
                begin
                    n = len;
                end
                emit    = (n != 5'd0);
                advance = 1'b1;
            end
            PH_IDLE, PH_DONE:
            begin
            end
            default:
            begin
            end
        endcase

        prod_new = eff_prod + 24'(n);
        wr_sum   = {1'b0, eff_wr} + (AW+1)'(n);
        if (wr_sum >= DEPTH_EXT)
        begin
            wr_sum = wr_sum - DEPTH_EXT;
        end

        if (advance)
        begin
            prod_next = prod_new;
            wr_next   = wr_sum[AW-1:0];
            bit_next  = bit_new;
            if (prod_new >= eff_target)
            begin
                phase_next = PH_DONE;
            end
            else if (bit_new[3])
            begin
                phase_next = PH_FLAG;
            end
            else
            begin
                phase_next = PH_BITS;
            end
        end

        if (finish)
        begin
            prod_next  = 24'd0;
            wr_next    = '0;
            flag_next  = 8'd0;
            bit_next   = 4'd0;
            th_next    = 8'd0;
            phase_next = (target_next == 24'd0) ? PH_DONE : PH_FLAG;
        end

        if (in_last)
        begin
            phase_next = PH_IDLE;
        end

        cmd_info.count    = n;
        cmd_info.done_end = (prod_new == eff_target);
        cmd_info.size     = eff_target;
    end

    assign cmd_valid = accept && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            hc_reg     <= 3'd0;
            held_reg   <= 16'd0;
            target_reg <= 24'd0;
            prod_reg   <= 24'd0;
            flag_reg   <= 8'd0;
            bit_reg    <= 4'd0;
            th_reg     <= 8'd0;
            wr_reg     <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            hc_reg     <= hc_next;
            held_reg   <= held_next;
            target_reg <= target_next;
            prod_reg   <= prod_next;
            flag_reg   <= flag_next;
            bit_reg    <= bit_next;
            th_reg     <= th_next;
            wr_reg     <= wr_next;
        end
    end

    // The parser never counts more output than the header announced.
    a_prod_within_target: assert property (@(posedge clk) disable iff (!rst_n)
        prod_reg <= target_reg)
        else $error("produced count passed the decoded size");

endmodule

>>> rtl/lzwd_cmd_fifo.sv
module lzwd_cmd_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = lzwd_pkg::CMD_QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("command queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("command queue read while empty");

endmodule

>>> rtl/lzwd_back.sv
module lzwd_back #(
    parameter int unsigned HISTORY_DEPTH = lzwd_pkg::HISTORY_DEPTH_DEF,
    parameter int unsigned AW = $clog2(HISTORY_DEPTH)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_pop,
    input  lzwd_pkg::cmd_info_t cmd_info,
    input  logic [AW-1:0]       cmd_rd_idx,
    input  logic [AW-1:0]       cmd_wr_idx,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_byte,
    output logic                out_last,
    output logic                out_done,
    output logic [23:0]         out_size
);

    import lzwd_pkg::*;

    // Issue stage: walks the current command one byte per cycle unless the data stage stalls.
    logic          busy_reg;
    logic [4:0]    cnt_reg;
    logic [AW-1:0] rd_idx_reg;
    logic [AW-1:0] wr_idx_reg;
    cmd_info_t     info_reg;

    // Data stage: the byte whose history read is in flight.
    logic          s2_valid_reg;
    logic [AW-1:0] s2_addr_reg;
    logic          s2_lit_reg;
    logic [7:0]    s2_data_reg;
    logic          s2_fwd_reg;
    logic          s2_last_reg;
    logic          s2_done_reg;
    logic [23:0]   s2_size_reg;

    // Output register and the most recently written byte.
    logic          out_valid_reg;
    logic [7:0]    out_byte_reg;
    logic          out_last_reg;
    logic          out_done_reg;
    logic [23:0]   out_size_reg;
    logic [7:0]    last_byte_reg;

    logic          issue;
    logic          adv;
    logic          rd_en;
    logic [7:0]    rd_data;
    logic [7:0]    byte_next;

    function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
        return (p == AW'(HISTORY_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign cmd_pop = cmd_valid && !busy_reg;
    assign adv     = s2_valid_reg && (!out_valid_reg || out_ready);
    assign issue   = busy_reg && (!s2_valid_reg || adv);
    assign rd_en   = issue && !info_reg.is_lit;

    // At distance one the source byte is still being written when it is
    // read, so it is taken from the last byte register instead.
    always_comb
    begin
        if (s2_lit_reg)
        begin
            byte_next = s2_data_reg;
        end
        else if (s2_fwd_reg)
        begin
            byte_next = last_byte_reg;
        end
        else
        begin
            byte_next = rd_data;
        end
    end

    lzwd_ram #(
        .WIDTH (8),
        .DEPTH (HISTORY_DEPTH)
    ) u_history (
        .clk     (clk),
        .wr_en   (adv),
        .wr_addr (s2_addr_reg),
        .wr_data (byte_next),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= 5'd0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_pop)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= cmd_info.count;
            end
            else if (issue)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    busy_reg <= 1'b0;
                end
            end

            if (issue)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (adv)
            begin
                s2_valid_reg <= 1'b0;
            end

            if (adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            info_reg   <= cmd_info;
            rd_idx_reg <= cmd_rd_idx;
            wr_idx_reg <= cmd_wr_idx;
        end
        else if (issue)
        begin
            rd_idx_reg <= bump(rd_idx_reg);
            wr_idx_reg <= bump(wr_idx_reg);
        end

        if (issue)
        begin
            s2_addr_reg <= wr_idx_reg;
            s2_lit_reg  <= info_reg.is_lit;
            s2_data_reg <= info_reg.data;
            s2_fwd_reg  <= info_reg.dist_one;
            s2_last_reg <= (cnt_reg == 5'd1);
            s2_done_reg <= (cnt_reg == 5'd1) && info_reg.done_end;
            s2_size_reg <= info_reg.size;
        end

        if (adv)
        begin
            out_byte_reg  <= byte_next;
            out_last_reg  <= s2_last_reg;
            out_done_reg  <= s2_done_reg;
            out_size_reg  <= s2_size_reg;
            last_byte_reg <= byte_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;
    assign out_done  = out_done_reg;
    assign out_size  = out_size_reg;

    a_busy_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg != 5'd0))
        else $error("copy engine busy with an empty command");

    a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && s2_done_reg) |-> s2_last_reg)
        else $error("size reached on a byte that does not end its run");

endmodule

>>> test/lzss_window_decompressor_tb.sv
module lzss_window_decompressor_tb;

    import lzwd_pkg::*;

    localparam int HIST_DEPTH    = HISTORY_DEPTH_DEF;
    localparam int TOTAL_ITEMS   = 360;
    // Four queued commands of up to 18 bytes each may still be in flight.
    localparam int SETTLE_CYCLES = 100;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int OPENING_ROWS  = 26;

    // One decoded beat as it should leave the m_axis side.
    typedef struct packed {
        logic [7:0]  data;
        logic        run_end;
        logic        done;
        logic [23:0] size;
    } out_beat_t;

    // One row of the opening sequence; typed_out rows carry their single result.
    typedef struct packed {
        logic [7:0]  data;
        logic        start;
        logic        last;
        logic        typed_out;
        logic [7:0]  out_data;
        logic        out_done;
        logic [23:0] out_size;
    } opening_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] in_byte
    logic        s_axis_tuser = 1'b0;    // [0] stream_start
    logic        s_axis_tlast = 1'b0;    // stream_last
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;           // [7:0] out_byte, [31:8] expected_size
    logic        m_axis_tuser;           // [0] stream_done
    logic        m_axis_tlast;           // run_last

    // Decoder state kept alongside the block.
    phase_t      dec_phase;
    logic [2:0]  hdr_count;
    logic [15:0] hdr_held;
    logic [23:0] dec_size;
    logic [23:0] dec_count;
    logic [7:0]  flag_byte;
    logic [3:0]  flag_pos;
    logic [7:0]  tok_hi;
    logic [7:0]  dec_hist [HIST_DEPTH];

    out_beat_t   pending_beats [$];
    out_beat_t   expected_beats [$];

    // Stream generator state.
    logic [7:0]  hdr_bytes [$];
    int          gen_left;
    logic        gen_close;
    logic        gen_first;
    logic [7:0]  tok_lo;

    int send_idle_pct;
    int recv_idle_pct;
    int busy_items;
    int beats_sent;
    int buffers_started;
    int beats_checked;
    int mismatches;
    int cycle_count;

    // Opening sequence: an untagged buffer with literals, a distance-one run and
    // a copy cut at the decoded size; a tagged buffer with a copy that reaches
    // before the first output byte, abandoned by a new start that carries a near
    // tag; a zero-size buffer; and one stray byte outside any buffer.
    opening_row_t opening_rows [OPENING_ROWS] = '{
        '{8'h06, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 24'd0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 24'd0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 24'd0},
        '{8'h05, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 24'd0},
        '{8'hFF, 1'b0, 1'b0, 1'b1, 8'hFF, 1'b0, 24'd6},
        '{8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 24'd0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 24'd0},
        '{8'h00, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0, 24'd6},
        '{8'hF0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 24'd0},
        '{8'h00, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 24'd0},
        '{8'h4C, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 24'd0},
        '{8'h5A, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 24'd0},
        '{8'h10, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 24'd0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 24'd0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 24'd0},
        '{8'h01, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 24'd0},
        '{8'hA5, 1'b0, 1'b0, 1'b1, 8'hA5, 1'b0, 24'd16},
        '{8'h20, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 24'd0},
        '{8'h01, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 24'd0},
        '{8'h4C, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 24'd0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 24'd0},
        '{8'h00, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 24'd0},
        '{8'h00, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 24'd0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 24'd0},
        '{8'h00, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 24'd0},
        '{8'h7E, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 24'd0}
    };

    lzss_window_decompressor i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 clk = ~clk;

    function automatic void reset_decoder();
        dec_phase = PH_IDLE;
        hdr_count = '0;
        hdr_held  = '0;
        dec_size  = '0;
        dec_count = '0;
        flag_byte = '0;
        flag_pos  = '0;
        tok_hi    = '0;
        foreach (dec_hist[k])
            dec_hist[k] = 8'h00;
    endfunction

    function automatic void start_body();
        dec_count = '0;
        flag_byte = '0;
        flag_pos  = '0;
        tok_hi    = '0;
        dec_phase = (dec_size == 24'd0) ? PH_DONE : PH_FLAG;
    endfunction

    function automatic void emit_byte(input logic [7:0] b);
        out_beat_t beat;
        dec_hist[dec_count % HIST_DEPTH] = b;
        dec_count = dec_count + 24'd1;
        beat = '{data: b, run_end: 1'b0, done: (dec_count == dec_size), size: dec_size};
        pending_beats = {pending_beats, beat};
    endfunction

    function automatic void step_flag();
        flag_pos = flag_pos + 4'd1;
        if (dec_count >= dec_size)
            dec_phase = PH_DONE;
        else if (flag_pos >= 4'd8)
            dec_phase = PH_FLAG;
        else
            dec_phase = PH_BITS;
    endfunction

    // Works out the decoded beats caused by one compressed beat.
    function automatic void decode_byte(input logic [7:0] b, input logic st, input logic la);
        logic [4:0]  run_len;
        logic [12:0] back;
        pending_beats.delete();
        if (st)
        begin
            dec_phase = PH_HEADER;
            hdr_count = '0;
            hdr_held  = '0;
            dec_size  = '0;
            dec_count = '0;
        end
        case (dec_phase)
            PH_HEADER:
            begin
                if (hdr_count == 3'd0)
                    hdr_held = {8'h00, b};
                else if (hdr_count == 3'd1)
                    hdr_held[15:8] = b;
                else if (hdr_count == 3'd2)
                begin
                    if (hdr_held == HEADER_TAG)
                        dec_size = {16'h0000, b};
                    else
                    begin
                        dec_size = {b, hdr_held};
                        start_body();
                    end
                end
                else if (hdr_count == 3'd3)
                    dec_size[15:8] = b;
                else
                begin
                    dec_size[23:16] = b;
                    start_body();
                end
                hdr_count = hdr_count + 3'd1;
            end
            PH_FLAG:
            begin
                flag_byte = b;
                flag_pos  = '0;
                dec_phase = PH_BITS;
            end
            PH_BITS:
            begin
                if (flag_byte[flag_pos[2:0]])
                begin
                    emit_byte(b);
                    step_flag();
                end
                else
                begin
                    tok_hi    = b;
                    dec_phase = PH_TOKEN2;
                end
            end
            PH_TOKEN2:
            begin
                run_len = {1'b0, tok_hi[7:4]} + MIN_MATCH;
                back    = {1'b0, tok_hi[3:0], b} + 13'd1;
                // The copy ends at the decoded size or where its source would
                // lie before the first output byte.
                for (int i = 0; i < run_len; i++)
                begin
                    if (dec_count >= dec_size || dec_count < back)
                        break;
                    emit_byte(dec_hist[(dec_count - back) % HIST_DEPTH]);
                end
                step_flag();
            end
            default:
            begin
            end
        endcase
        if (la)
            dec_phase = PH_IDLE;
        if (pending_beats.size() != 0)
            pending_beats[pending_beats.size() - 1].run_end = 1'b1;
    endfunction

    // Offers one compressed beat, after a random gap, and books its results.
    task automatic push_beat(input logic [7:0] b, input logic st, input logic la,
                             input logic use_typed, input out_beat_t typed_beat);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= st;
        s_axis_tlast  <= la;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (st || (dec_phase != PH_IDLE && dec_phase != PH_DONE))
            busy_items++;
        beats_sent++;
        decode_byte(b, st, la);
        if (use_typed)
            expected_beats = {expected_beats, typed_beat};
        else
            foreach (pending_beats[k])
                expected_beats = {expected_beats, pending_beats[k]};
    endtask

    // The sender holds off until the block has delivered everything booked.
    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (expected_beats.size() != 0);
    endtask

    // Picks the header and length of the next generated buffer.
    task automatic plan_stream();
        logic [23:0] size;
        int          pick;
        hdr_bytes.delete();
        pick = $urandom_range(0, 99);
        if (pick < 10)
            size = 24'd0;
        else if (pick < 75)
            size = 24'($urandom_range(1, 90));
        else
            size = 24'($urandom);
        if ($urandom_range(0, 1) == 1)
        begin
            hdr_bytes = {hdr_bytes, TAG_CHAR_L};
            hdr_bytes = {hdr_bytes, TAG_CHAR_Z};
        end
        else if ($urandom_range(0, 9) == 0)
            size[7:0] = TAG_CHAR_L;   // starts like a tag; the second byte decides
        hdr_bytes = {hdr_bytes, size[7:0]};
        hdr_bytes = {hdr_bytes, size[15:8]};
        hdr_bytes = {hdr_bytes, size[23:16]};
        gen_left  = hdr_bytes.size() + $urandom_range(4, 44);
        gen_close = ($urandom_range(0, 9) != 0);
        gen_first = 1'b1;
        buffers_started++;
    endtask

    // Produces the next byte of a mostly well-formed buffer. Token distances
    // mostly point into bytes already decoded, often close by.
    task automatic send_random_beat();
        logic [7:0]  b;
        logic        st;
        logic        la;
        logic [11:0] d;
        int          span;
        int          reach;
        if (gen_left == 0 || $urandom_range(0, 99) < 2)
        begin
            if ($urandom_range(0, 99) < 15)
                repeat ($urandom_range(1, 3))
                    push_beat(8'($urandom), 1'b0, ($urandom_range(0, 7) == 0), 1'b0, '0);
            plan_stream();
        end
        st = 1'b0;
        if (hdr_bytes.size() != 0)
        begin
            b         = hdr_bytes.pop_front();
            st        = gen_first;
            gen_first = 1'b0;
        end
        else
        begin
            case (dec_phase)
                PH_BITS:
                begin
                    b = 8'($urandom);
                    if (!flag_byte[flag_pos[2:0]])
                    begin
                        if (dec_count != 0 && $urandom_range(0, 99) < 85)
                        begin
                            span  = (dec_count > HIST_DEPTH) ? HIST_DEPTH : int'(dec_count);
                            reach = ($urandom_range(0, 1) == 1 && span > 16) ? 16 : span;
                            d     = 12'($urandom_range(0, reach - 1));
                        end
                        else
                            d = 12'($urandom_range(0, 4095));
                        b      = {4'($urandom_range(0, 15)), d[11:8]};
                        tok_lo = d[7:0];
                    end
                end
                PH_TOKEN2:
                    b = tok_lo;
                default:
                    b = 8'($urandom);
            endcase
        end
        gen_left--;
        la = (gen_left == 0) && gen_close;
        push_beat(b, st, la, 1'b0, '0);
    endtask

    // Receiver: stalls at random at the current rate.
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // Compare every delivered beat with the oldest booked one.
    always @(posedge clk)
    begin
        out_beat_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            beats_checked++;
            if (expected_beats.size() == 0)
            begin
                $error("decoded beat out_byte=%02h arrived with nothing booked",
                       m_axis_tdata[7:0]);
                mismatches++;
            end
            else
            begin
                want = expected_beats.pop_front();
                if (m_axis_tdata[7:0] !== want.data)
                begin
                    $error("out_byte: expected %02h, got %02h", want.data, m_axis_tdata[7:0]);
                    mismatches++;
                end
                if (m_axis_tlast !== want.run_end)
                begin
                    $error("run_last: expected %0b, got %0b", want.run_end, m_axis_tlast);
                    mismatches++;
                end
                if (m_axis_tuser !== want.done)
                begin
                    $error("stream_done: expected %0b, got %0b", want.done, m_axis_tuser);
                    mismatches++;
                end
                if (m_axis_tdata[31:8] !== want.size)
                begin
                    $error("expected_size: expected %06h, got %06h",
                           want.size, m_axis_tdata[31:8]);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d beats still booked",
                     cycle_count, expected_beats.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        reset_decoder();
        send_idle_pct = 35;
        recv_idle_pct = 73;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        hold_until_drained();

        foreach (opening_rows[r])
            push_beat(opening_rows[r].data, opening_rows[r].start, opening_rows[r].last,
                      opening_rows[r].typed_out,
                      '{data: opening_rows[r].out_data, run_end: 1'b1,
                        done: opening_rows[r].out_done, size: opening_rows[r].out_size});

        // Three stall profiles: sender-light, receiver-light, and none.
        for (int ph = 0; ph < 3; ph++)
        begin
            if (ph == 1)
            begin
                hold_until_drained();
                send_idle_pct = 73;
                recv_idle_pct = 35;
            end
            else if (ph == 2)
            begin
                hold_until_drained();
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            while (beats_sent < (ph + 1) * TOTAL_ITEMS / 3)
                send_random_beat();
        end

        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Drove %0d compressed beats (%0d decoded by the parser) over %0d buffers,",
                 beats_sent, busy_items, buffers_started + 4);
        $display("and checked %0d decoded beats under three stall profiles.", beats_checked);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
